[src/contact_penalty_force_accumulator_defines.svh]
// ----------------------------------------------------------------------------
// Contact penalty force accumulator - assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef CONTACT_PENALTY_FORCE_ACCUMULATOR_DEFINES_SVH
`define CONTACT_PENALTY_FORCE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPFA_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cpfa check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPFA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cpfa check failed");

`endif

[src/cpfa_pkg.sv]
// ----------------------------------------------------------------------------
// cpfa_pkg
// Types and constants shared by the contact penalty force accumulator.
// ----------------------------------------------------------------------------
package cpfa_pkg;

  localparam logic KIND_DISC    = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  // register index as seen on the word address bit
  localparam logic REG_CONTACT_SCALE = 1'b0;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned T_STEPS    = 30;  // quotient bits of the projection
  localparam int unsigned SQRT_STEPS = 28;  // root bits of the distance
  localparam int unsigned DIV_STEPS  = 26;  // quotient bits of the force ratio

  typedef struct packed {
    logic               kind;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic [24:0]        self_radius;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic [24:0]        other_radius;
    logic signed [31:0] segment_end_x;
    logic signed [31:0] segment_end_y;
    logic               last;
  } item_t;

  // offset to the nearest neighbor point, already checked against the far limit
  typedef struct packed {
    logic signed [28:0] dx;
    logic signed [28:0] dy;
    logic [25:0]        reach;
    logic               far;
    logic               last;
  } job_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               saturated;
  } result_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PREP, F_MUL, F_TEST, F_DIV, F_ALONG, F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE, B_SQ0, B_SQ1, B_SQRT, B_CHK, B_PROD, B_DIV, B_SCALE, B_ADD, B_FIN
  } back_state_e;

endpackage

[src/cpfa_fifo.sv]
// ----------------------------------------------------------------------------
// cpfa_fifo
// Short job queue between the geometry front and the force back.
// ----------------------------------------------------------------------------
module cpfa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpfa_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cpfa_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(cpfa_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(cpfa_pkg::FIFO_DEPTH + 1);

  cpfa_pkg::job_t mem_q [cpfa_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(cpfa_pkg::FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(cpfa_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(cpfa_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/cpfa_front.sv]
// ----------------------------------------------------------------------------
// cpfa_front
// Accepts a neighbor item, projects onto wall segments, queues the offset.
// ----------------------------------------------------------------------------
module cpfa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  cpfa_pkg::item_t item_i,
  output logic            push_o,
  output cpfa_pkg::job_t  job_o,
  input  logic            full_i
);

  localparam logic signed [34:0] FarPos = 35'sd134217728;
  localparam logic signed [34:0] FarNeg = -35'sd134217728;
  localparam logic [30:0]        TOne   = 31'h4000_0000;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [30:0] shrink(input logic signed [32:0] v,
                                                input logic [1:0] k);
    logic [32:0] m;
    m = mag33(v) >> k;
    return v[32] ? -$signed(m[30:0]) : $signed(m[30:0]);
  endfunction

  cpfa_pkg::front_state_e state_q, state_d;

  logic               last_q;
  logic signed [32:0] ex_q, ey_q, wx_q, wy_q;
  logic [25:0]        reach_q;
  logic signed [30:0] rex_q, rey_q, rwx_q, rwy_q;
  logic signed [61:0] dot_q, len2_q;
  logic [62:0]        rem_q;
  logic [30:0]        t_q;
  logic signed [33:0] alx_q, aly_q;
  logic [4:0]         cnt_q;

  logic               accept;
  logic [32:0]        mx;
  logic [1:0]         k;
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] mul_p;
  logic [62:0]        r2;
  logic               r_ge;
  logic signed [32:0] al_e;
  logic [32:0]        al_mag;
  logic [63:0]        al_p;
  logic signed [33:0] al_s;
  logic signed [34:0] dx, dy;
  logic               do_div, test_one;

  assign accept = (state_q == cpfa_pkg::F_IDLE) && item_valid_i;

  // largest magnitude picks the common shift that keeps products in range
  always_comb begin
    mx = mag33(ex_q);
    if (mag33(ey_q) > mx) mx = mag33(ey_q);
    if (mag33(wx_q) > mx) mx = mag33(wx_q);
    if (mag33(wy_q) > mx) mx = mag33(wy_q);
    if (mx < 33'h0_4000_0000)      k = 2'd0;
    else if (mx < 33'h0_8000_0000) k = 2'd1;
    else if (mx < 33'h1_0000_0000) k = 2'd2;
    else                           k = 2'd3;
  end

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    begin mul_a = rex_q; mul_b = rwx_q; end
      2'd1:    begin mul_a = rey_q; mul_b = rwy_q; end
      2'd2:    begin mul_a = rex_q; mul_b = rex_q; end
      default: begin mul_a = rey_q; mul_b = rey_q; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign do_div   = (len2_q > 62'sd0) && (dot_q > 62'sd0);
  assign test_one = (dot_q >= len2_q);

  assign r2   = {rem_q[61:0], 1'b0};
  assign r_ge = (r2 >= {1'b0, len2_q});

  assign al_e   = cnt_q[0] ? ey_q : ex_q;
  assign al_mag = mag33(al_e);
  assign al_p   = 64'(al_mag) * 64'(t_q);
  assign al_s   = al_e[32] ? -$signed({1'b0, al_p[62:30]}) : $signed({1'b0, al_p[62:30]});

  assign dx = $signed({{2{wx_q[32]}}, wx_q}) - $signed({alx_q[33], alx_q});
  assign dy = $signed({{2{wy_q[32]}}, wy_q}) - $signed({aly_q[33], aly_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpfa_pkg::F_IDLE: begin
        if (item_valid_i) begin
          state_d = (item_i.kind == cpfa_pkg::KIND_SEGMENT) ? cpfa_pkg::F_PREP
                                                          : cpfa_pkg::F_PUSH;
        end
      end
      cpfa_pkg::F_PREP: state_d = cpfa_pkg::F_MUL;
      cpfa_pkg::F_MUL:  if (cnt_q == 5'd3) state_d = cpfa_pkg::F_TEST;
      cpfa_pkg::F_TEST: state_d = (do_div && !test_one) ? cpfa_pkg::F_DIV : cpfa_pkg::F_ALONG;
      cpfa_pkg::F_DIV:  if (cnt_q == 5'(cpfa_pkg::T_STEPS - 1)) state_d = cpfa_pkg::F_ALONG;
      cpfa_pkg::F_ALONG: if (cnt_q == 5'd1) state_d = cpfa_pkg::F_PUSH;
      cpfa_pkg::F_PUSH: if (!full_i) state_d = cpfa_pkg::F_IDLE;
      default:          state_d = cpfa_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    item_ready_o = (state_q == cpfa_pkg::F_IDLE);
    push_o       = (state_q == cpfa_pkg::F_PUSH) && !full_i;
    job_o.dx     = dx[28:0];
    job_o.dy     = dy[28:0];
    job_o.reach  = reach_q;
    job_o.far    = (dx > FarPos) || (dx < FarNeg) || (dy > FarPos) || (dy < FarNeg);
    job_o.last   = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpfa_pkg::F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else                    cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= item_i.last;
      ex_q   <= $signed({item_i.segment_end_x[31], item_i.segment_end_x})
              - $signed({item_i.other_x[31], item_i.other_x});
      ey_q   <= $signed({item_i.segment_end_y[31], item_i.segment_end_y})
              - $signed({item_i.other_y[31], item_i.other_y});
      wx_q   <= $signed({item_i.self_x[31], item_i.self_x})
              - $signed({item_i.other_x[31], item_i.other_x});
      wy_q   <= $signed({item_i.self_y[31], item_i.self_y})
              - $signed({item_i.other_y[31], item_i.other_y});
      reach_q <= (item_i.kind == cpfa_pkg::KIND_SEGMENT) ? {1'b0, item_i.self_radius}
                 : 26'(item_i.self_radius) + 26'(item_i.other_radius);
      t_q    <= '0;
      alx_q  <= '0;
      aly_q  <= '0;
    end
    unique case (state_q)
      cpfa_pkg::F_PREP: begin
        rex_q  <= shrink(ex_q, k);
        rey_q  <= shrink(ey_q, k);
        rwx_q  <= shrink(wx_q, k);
        rwy_q  <= shrink(wy_q, k);
        dot_q  <= '0;
        len2_q <= '0;
      end
      cpfa_pkg::F_MUL: begin
        if (cnt_q[1]) len2_q <= len2_q + mul_p;
        else          dot_q  <= dot_q + mul_p;
      end
      cpfa_pkg::F_TEST: begin
        rem_q <= {1'b0, dot_q};
        t_q   <= (do_div && test_one) ? TOne : '0;
      end
      cpfa_pkg::F_DIV: begin
        rem_q <= r_ge ? (r2 - {1'b0, len2_q}) : r2;
        t_q   <= {t_q[29:0], r_ge};
      end
      cpfa_pkg::F_ALONG: begin
        if (cnt_q[0]) aly_q <= al_s;
        else          alx_q <= al_s;
      end
      default: ;
    endcase
  end

endmodule

[src/cpfa_back.sv]
// ----------------------------------------------------------------------------
// cpfa_back
// Turns queued offsets into penalty forces and keeps the saturating sums.
// ----------------------------------------------------------------------------
module cpfa_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  cpfa_pkg::job_t    job_i,
  output logic              pop_o,
  input  logic [23:0]       scale_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpfa_pkg::result_t result_o
);

  localparam logic signed [51:0] SumHi = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [51:0] SumLo = 52'shF_8000_0000_0000;
  localparam logic signed [47:0] OutHi = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] OutLo = 48'shFFFF_8000_0000;

  function automatic logic [27:0] mag29(input logic signed [28:0] v);
    return v[28] ? 28'(-v) : 28'(v);
  endfunction

  cpfa_pkg::back_state_e state_q, state_d;

  cpfa_pkg::job_t     job_q;
  logic               axis_q;
  logic [55:0]        n_q, root_q, bit_q;
  logic [4:0]         cnt_q;
  logic [27:0]        dist_q;
  logic [25:0]        ov_q;
  logic [53:0]        prod_q;
  logic [27:0]        rem_q;
  logic [25:0]        quo_q;
  logic [49:0]        f_q;
  logic signed [47:0] sum_x_q, sum_y_q;
  logic               clip_q;
  logic               out_valid_q;
  cpfa_pkg::result_t  result_q;

  logic               skip;
  logic signed [28:0] sq_op;
  logic signed [57:0] sq_p;
  logic [55:0]        rb;
  logic               no_force;
  logic [27:0]        mag_sel;
  logic [53:0]        pm_p;
  logic [27:0]        rem_base;
  logic [28:0]        dr2;
  logic               d_ge;
  logic [49:0]        sc_p;
  logic signed [47:0] acc;
  logic signed [51:0] acc_e, f_e, s;
  logic signed [47:0] s_sat;
  logic               s_clip;
  logic               emit;
  logic               hi_x, lo_x, hi_y, lo_y;

  assign skip     = job_i.far || (scale_i == '0);
  assign sq_op    = (state_q == cpfa_pkg::B_SQ0) ? job_q.dx : job_q.dy;
  assign sq_p     = sq_op * sq_op;
  assign rb       = root_q + bit_q;
  assign no_force = (root_q[27:0] == '0) || ({2'b0, job_q.reach} <= root_q[27:0]);
  assign mag_sel  = axis_q ? mag29(job_q.dy) : mag29(job_q.dx);
  assign pm_p     = 54'(mag_sel) * 54'(ov_q);
  assign rem_base = (cnt_q == '0) ? prod_q[53:26] : rem_q;
  assign dr2      = {rem_base, prod_q[25]};
  assign d_ge     = (dr2 >= {1'b0, dist_q});
  assign sc_p     = 50'(quo_q) * 50'(scale_i);

  // signed sum with a saturating clamp at the 48 bit limits
  always_comb begin
    acc   = axis_q ? sum_y_q : sum_x_q;
    acc_e = {{4{acc[47]}}, acc};
    f_e   = $signed({2'b0, f_q});
    s     = (axis_q ? job_q.dy[28] : job_q.dx[28]) ? acc_e - f_e : acc_e + f_e;
    s_clip = 1'b1;
    if (s > SumHi)      s_sat = SumHi[47:0];
    else if (s < SumLo) s_sat = SumLo[47:0];
    else begin
      s_sat  = s[47:0];
      s_clip = 1'b0;
    end
  end

  assign hi_x = (sum_x_q > OutHi);
  assign lo_x = (sum_x_q < OutLo);
  assign hi_y = (sum_y_q > OutHi);
  assign lo_y = (sum_y_q < OutLo);

  assign emit = (state_q == cpfa_pkg::B_FIN) && job_q.last && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpfa_pkg::B_IDLE: begin
        if (job_valid_i) state_d = skip ? cpfa_pkg::B_FIN : cpfa_pkg::B_SQ0;
      end
      cpfa_pkg::B_SQ0:  state_d = cpfa_pkg::B_SQ1;
      cpfa_pkg::B_SQ1:  state_d = cpfa_pkg::B_SQRT;
      cpfa_pkg::B_SQRT: if (cnt_q == 5'(cpfa_pkg::SQRT_STEPS - 1)) state_d = cpfa_pkg::B_CHK;
      cpfa_pkg::B_CHK:  state_d = no_force ? cpfa_pkg::B_FIN : cpfa_pkg::B_PROD;
      cpfa_pkg::B_PROD: state_d = cpfa_pkg::B_DIV;
      cpfa_pkg::B_DIV:  if (cnt_q == 5'(cpfa_pkg::DIV_STEPS - 1)) state_d = cpfa_pkg::B_SCALE;
      cpfa_pkg::B_SCALE: state_d = cpfa_pkg::B_ADD;
      cpfa_pkg::B_ADD:  state_d = axis_q ? cpfa_pkg::B_FIN : cpfa_pkg::B_PROD;
      cpfa_pkg::B_FIN:  if (!job_q.last || emit) state_d = cpfa_pkg::B_IDLE;
      default:          state_d = cpfa_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == cpfa_pkg::B_IDLE) && job_valid_i;
    out_valid_o = out_valid_q;
    result_o    = result_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpfa_pkg::B_IDLE;
      cnt_q       <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else                    cnt_q <= cnt_q + 1'b1;
      if (state_q == cpfa_pkg::B_CHK) axis_q <= 1'b0;
      if (state_q == cpfa_pkg::B_ADD) begin
        axis_q <= 1'b1;
        if (axis_q) sum_y_q <= s_sat;
        else        sum_x_q <= s_sat;
        if (s_clip) clip_q <= 1'b1;
      end
      if (emit) begin
        sum_x_q     <= '0;
        sum_y_q     <= '0;
        clip_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    unique case (state_q)
      cpfa_pkg::B_SQ0: n_q <= sq_p[55:0];
      cpfa_pkg::B_SQ1: begin
        n_q    <= n_q + sq_p[55:0];
        root_q <= '0;
        bit_q  <= 56'(1) << 54;
      end
      cpfa_pkg::B_SQRT: begin
        if (n_q >= rb) begin
          n_q    <= n_q - rb;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      cpfa_pkg::B_CHK: begin
        dist_q <= root_q[27:0];
        ov_q   <= job_q.reach - root_q[25:0];
      end
      cpfa_pkg::B_PROD: prod_q <= pm_p;
      cpfa_pkg::B_DIV: begin
        rem_q  <= d_ge ? 28'(dr2 - {1'b0, dist_q}) : dr2[27:0];
        quo_q  <= {quo_q[24:0], d_ge};
        prod_q <= prod_q << 1;
      end
      cpfa_pkg::B_SCALE: f_q <= sc_p >> FRAC_BITS;
      default: ;
    endcase
    if (emit) begin
      result_q.force_x   <= hi_x ? OutHi[31:0] : (lo_x ? OutLo[31:0] : sum_x_q[31:0]);
      result_q.force_y   <= hi_y ? OutHi[31:0] : (lo_y ? OutLo[31:0] : sum_y_q[31:0]);
      result_q.saturated <= clip_q || hi_x || lo_x || hi_y || lo_y;
    end
  end

endmodule

[src/contact_penalty_force_accumulator.sv]
// ----------------------------------------------------------------------------
// contact_penalty_force_accumulator
// Sums 2D soft-contact repulsion on one disc agent over a neighbor stream.
// ----------------------------------------------------------------------------
// Usage:
//   Stream one item per neighbor on the s_axis channel: tuser selects a disc
//   neighbor or a wall segment, tlast marks the final neighbor of a run.
//   Each item with tlast set yields one item on m_axis: the summed force,
//   clipped to 32 bits, with tuser flagging any clipping during the run.
//   contact_scale is written over the APB port; the user must keep writes to
//   times when the block is idle, as the block itself does not enforce it.
// Datapath:
//   The front takes one item at a time: a disc goes straight to the queue,
//   a segment is first projected, with a bit-serial divide only when the
//   projection falls inside the segment. The back takes a square root and
//   runs two force dividers, one quotient bit a cycle. Items without overlap
//   skip the dividers, far or disabled items also skip the square root. For
//   contributing items the back sets the sustained rate; a two-entry queue
//   lets the front work ahead.
// Reset clears the sums, the clip flag, the scale and all control state.
// A stalled receiver holds the result in the output register; the block
// keeps working until a second result must be written.
// ----------------------------------------------------------------------------
module contact_penalty_force_accumulator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // neighbor items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] self_x, [63:32] self_y, [88:64] self_radius, [120:89] other_x,
  // [152:121] other_y, [177:153] other_radius, [209:178] segment_end_x,
  // [241:210] segment_end_y, [247:242] zero
  input  logic [247:0] s_axis_tdata,
  // [0] neighbor_kind
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  // force results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] force_x, [63:32] force_y
  output logic [63:0]  m_axis_tdata,
  // [0] saturated
  output logic         m_axis_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [23:0]       scale_q;
  cpfa_pkg::item_t   item;
  logic              push, full, job_valid, pop;
  cpfa_pkg::job_t    push_job, pop_job;
  cpfa_pkg::result_t result;

  // register file: contact_scale only, word addressed
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cpfa_pkg::REG_CONTACT_SCALE) ? {8'b0, scale_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == cpfa_pkg::REG_CONTACT_SCALE)) begin
      scale_q <= pwdata[23:0];
    end
  end

  // unpack the input item
  always_comb begin
    item.kind          = s_axis_tuser;
    item.self_x        = s_axis_tdata[31:0];
    item.self_y        = s_axis_tdata[63:32];
    item.self_radius   = s_axis_tdata[88:64];
    item.other_x       = s_axis_tdata[120:89];
    item.other_y       = s_axis_tdata[152:121];
    item.other_radius  = s_axis_tdata[177:153];
    item.segment_end_x = s_axis_tdata[209:178];
    item.segment_end_y = s_axis_tdata[241:210];
    item.last          = s_axis_tlast;
  end

  cpfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .push_o       (push),
    .job_o        (push_job),
    .full_i       (full)
  );

  cpfa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  cpfa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .scale_i     (scale_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {result.force_y, result.force_x};
  assign m_axis_tuser = result.saturated;

endmodule

[src/cpfa_checker.sv]
// ----------------------------------------------------------------------------
// cpfa_checker
// Port-level checks for the contact penalty force accumulator.
// ----------------------------------------------------------------------------
`include "contact_penalty_force_accumulator_defines.svh"

module cpfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a result waiting on the receiver stays offered
  `CPFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // the front is not ready in the cycle after taking an item
  `CPFA_ASSERT_NEXT(a_in_gap, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a scale write reads back on the following cycle
  `CPFA_ASSERT_NEXT(a_scale_rb, clk_i, rst_ni, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[23:0] == $past(pwdata[23:0])))

  // unused register addresses read as zero
  `CPFA_ASSERT_NOW(a_rd_zero, clk_i, rst_ni, psel && paddr[2], prdata == 32'd0)

endmodule

bind contact_penalty_force_accumulator cpfa_checker u_cpfa_checker (.*);
